[sv/hlc_pkg.sv]
// hlc_pkg: shared types and constants for the homogeneous line clipper
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package hlc_pkg;

  // six clip planes: +x, -x, +y, -y, +z, -z
  localparam int PLANES = 6;
  // four homogeneous coordinates per endpoint
  localparam int COORDS = 4;
  // width of the coordinate fields on the ports
  localparam int PORT_BITS = 32;
  // index of w among the coordinates
  localparam int W_IDX = 3;

  // per segment plane classification, carried alongside the divider
  typedef struct packed {
    logic [PLANES-1:0] code_a;
    logic [PLANES-1:0] code_b;
    logic [PLANES-1:0] leave;
    logic [PLANES-1:0] enter;
  } hlc_ctl_t;

  typedef logic [COORDS-1:0][PORT_BITS-1:0] hlc_point_t;

endpackage

[sv/hlc_if.sv]
// hlc_if: valid/ready channel interfaces for segment input and clipped output
// depends on nothing
`timescale 1ns / 1ps

interface hlc_seg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic signed [31:0] first_w;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;
  logic signed [31:0] second_w;

  modport source (output valid, first_x, first_y, first_z, first_w,
                  second_x, second_y, second_z, second_w, input ready);
  modport sink (input valid, first_x, first_y, first_z, first_w,
                second_x, second_y, second_z, second_w, output ready);
endinterface

interface hlc_clip_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic signed [31:0] clipped_first_x;
  logic signed [31:0] clipped_first_y;
  logic signed [31:0] clipped_first_z;
  logic signed [31:0] clipped_first_w;
  logic signed [31:0] clipped_second_x;
  logic signed [31:0] clipped_second_y;
  logic signed [31:0] clipped_second_z;
  logic signed [31:0] clipped_second_w;

  modport source (output valid, accepted, clipped_first_x, clipped_first_y,
                  clipped_first_z, clipped_first_w, clipped_second_x,
                  clipped_second_y, clipped_second_z, clipped_second_w,
                  input ready);
  modport sink (input valid, accepted, clipped_first_x, clipped_first_y,
                clipped_first_z, clipped_first_w, clipped_second_x,
                clipped_second_y, clipped_second_z, clipped_second_w,
                output ready);
endinterface

[sv/hlc_setup.sv]
// hlc_setup: boundary values, outcodes and divider operands, one register stage
// depends on hlc_pkg
`timescale 1ns / 1ps

module hlc_setup
  import hlc_pkg::*;
#(
  parameter int CB = 32,
  parameter int DW = 35
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  hlc_point_t                       raw_a,
  input  hlc_point_t                       raw_b,
  output logic                             out_valid,
  output logic [COORDS-1:0][CB-1:0]        pa,
  output logic [COORDS-1:0][CB-1:0]        pb,
  output hlc_ctl_t                         ctl,
  output logic [PLANES-1:0][CB:0]          num,
  output logic [PLANES-1:0][DW-1:0]        den
);

  logic signed [CB-1:0] ca [COORDS];
  logic signed [CB-1:0] cb [COORDS];
  logic signed [CB:0]   ba [PLANES];
  logic signed [CB:0]   bb [PLANES];
  hlc_ctl_t             ctl_c;
  logic [PLANES-1:0][CB:0]   num_c;
  logic [PLANES-1:0][DW-1:0] den_c;

  // take the low bits of each field as a signed coordinate
  always_comb begin
    for (int c = 0; c < COORDS; c++) begin
      ca[c] = signed'(CB'(raw_a[c]));
      cb[c] = signed'(CB'(raw_b[c]));
    end
  end

  // boundary values w+x, w-x, ... and plane classification
  always_comb begin
    ctl_c = '0;
    for (int i = 0; i < 3; i++) begin
      ba[2*i]   = (CB+1)'(ca[W_IDX]) + (CB+1)'(ca[i]);
      ba[2*i+1] = (CB+1)'(ca[W_IDX]) - (CB+1)'(ca[i]);
      bb[2*i]   = (CB+1)'(cb[W_IDX]) + (CB+1)'(cb[i]);
      bb[2*i+1] = (CB+1)'(cb[W_IDX]) - (CB+1)'(cb[i]);
    end
    for (int p = 0; p < PLANES; p++) begin
      ctl_c.code_a[p] = (ba[p] <= 0);
      ctl_c.code_b[p] = (bb[p] <= 0);
      num_c[p] = '0;
      den_c[p] = '0;
      if (bb[p] < 0) begin
        // segment leaves through this plane
        ctl_c.leave[p] = 1'b1;
        num_c[p] = unsigned'(ba[p]);
        den_c[p] = unsigned'(DW'(ba[p]) - DW'(bb[p]));
      end else if (ba[p] < 0) begin
        // segment enters through this plane
        ctl_c.enter[p] = 1'b1;
        num_c[p] = unsigned'(-ba[p]);
        den_c[p] = unsigned'(DW'(bb[p]) - DW'(ba[p]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < COORDS; c++) begin
        pa[c] <= ca[c];
        pb[c] <= cb[c];
      end
      ctl <= ctl_c;
      num <= num_c;
      den <= den_c;
    end
  end

endmodule

[sv/hlc_div.sv]
// hlc_div: six lane restoring divider, one quotient bit per pipeline stage
// depends on hlc_pkg
`timescale 1ns / 1ps

module hlc_div
  import hlc_pkg::*;
#(
  parameter int CB = 32,
  parameter int PF = 24,
  parameter int DW = 35,
  parameter int SW = 280
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [PLANES-1:0][CB:0]     num,
  input  logic [PLANES-1:0][DW-1:0]   den,
  input  logic [SW-1:0]               side_in,
  output logic                        out_valid,
  output logic [PLANES-1:0][PF-1:0]   quo,
  output logic [SW-1:0]               side_out
);

  logic                        v_s [1:PF];
  logic [PLANES-1:0][DW-1:0]   r_s [1:PF];
  logic [PLANES-1:0][DW-1:0]   d_s [1:PF];
  logic [PLANES-1:0][PF-1:0]   q_s [1:PF];
  logic [SW-1:0]               s_s [1:PF];

  for (genvar k = 0; k < PF; k++) begin : g_stg
    logic                      v_c;
    logic [PLANES-1:0][DW-1:0] r_c;
    logic [PLANES-1:0][DW-1:0] d_c;
    logic [PLANES-1:0][PF-1:0] q_c;
    logic [SW-1:0]             s_c;
    logic [PLANES-1:0][DW-1:0] r_n;
    logic [PLANES-1:0][PF-1:0] q_n;

    // stage source: the operands for the first stage, the previous stage after
    if (k == 0) begin : g_first
      always_comb begin
        v_c = in_valid;
        s_c = side_in;
        for (int l = 0; l < PLANES; l++) begin
          r_c[l] = DW'(num[l]);
          d_c[l] = den[l];
          q_c[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        v_c = v_s[k];
        s_c = s_s[k];
        r_c = r_s[k];
        d_c = d_s[k];
        q_c = q_s[k];
      end
    end

    // one shift and trial subtract per lane
    always_comb begin
      logic [DW-1:0] sh;
      logic          ge;
      for (int l = 0; l < PLANES; l++) begin
        sh     = {r_c[l][DW-2:0], 1'b0};
        ge     = (sh >= d_c[l]);
        r_n[l] = ge ? (sh - d_c[l]) : sh;
        q_n[l] = {q_c[l][PF-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_s[k+1] <= r_n;
        d_s[k+1] <= d_c;
        q_s[k+1] <= q_n;
        s_s[k+1] <= s_c;
      end
    end
  end

  assign out_valid = v_s[PF];
  assign quo       = q_s[PF];
  assign side_out  = s_s[PF];

endmodule

[sv/hlc_lerp.sv]
// hlc_lerp: parameter selection, reject test and endpoint interpolation
// three register stages; depends on hlc_pkg
`timescale 1ns / 1ps

module hlc_lerp
  import hlc_pkg::*;
#(
  parameter int CB = 32,
  parameter int PF = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [PLANES-1:0][PF-1:0]     quo,
  input  hlc_ctl_t                      ctl,
  input  logic [COORDS-1:0][CB-1:0]     pa,
  input  logic [COORDS-1:0][CB-1:0]     pb,
  output logic                          out_valid,
  output logic                          accepted,
  output hlc_point_t                    ra,
  output hlc_point_t                    rb
);

  localparam int TW = PF + 1;
  localparam int MW = CB + 1;
  localparam int PW = MW + TW;
  localparam int NL = 2 * COORDS;
  localparam logic [TW-1:0] T_ONE = TW'(1) << PF;

  // stage a: entry/exit parameters, reject decision, differences
  logic [TW-1:0] t_in_c, t_out_c;
  logic          acc_c, clip_c;
  logic [NL-1:0][MW-1:0] mag_c;
  logic [NL-1:0]         neg_c;

  always_comb begin
    logic signed [CB:0] d;
    t_in_c  = '0;
    t_out_c = T_ONE;
    for (int l = 0; l < PLANES; l++) begin
      if (ctl.leave[l] && (TW'(quo[l]) < t_out_c)) begin
        t_out_c = TW'(quo[l]);
      end else if (ctl.enter[l] && (TW'(quo[l]) > t_in_c)) begin
        t_in_c = TW'(quo[l]);
      end
    end
    clip_c = |(ctl.code_a | ctl.code_b);
    acc_c  = ~|(ctl.code_a & ctl.code_b) && !(clip_c && (t_in_c > t_out_c));
    for (int c = 0; c < COORDS; c++) begin
      d = (CB+1)'(signed'(pb[c])) - (CB+1)'(signed'(pa[c]));
      neg_c[c]        = d[CB];
      neg_c[c+COORDS] = d[CB];
      mag_c[c]        = d[CB] ? unsigned'(-d) : unsigned'(d);
      mag_c[c+COORDS] = mag_c[c];
    end
  end

  logic                      va, acc_a, mva, mvb;
  logic [TW-1:0]             tin_a, tout_a;
  logic [NL-1:0][MW-1:0]     mag_a;
  logic [NL-1:0]             neg_a;
  logic [COORDS-1:0][CB-1:0] pa_a, pb_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_a  <= acc_c;
      mva    <= clip_c && acc_c && (|ctl.code_a);
      mvb    <= clip_c && acc_c && (|ctl.code_b);
      tin_a  <= t_in_c;
      tout_a <= t_out_c;
      mag_a  <= mag_c;
      neg_a  <= neg_c;
      pa_a   <= pa;
      pb_a   <= pb;
    end
  end

  // stage b: offset magnitude = |d| * t, truncated
  logic [NL-1:0][MW:0] off_c;

  always_comb begin
    logic [PW-1:0] prod;
    for (int l = 0; l < NL; l++) begin
      prod     = PW'(mag_a[l]) * PW'((l < COORDS) ? tin_a : tout_a);
      off_c[l] = prod[PF +: MW+1];
    end
  end

  logic                      vb, acc_b, mva_b, mvb_b;
  logic [NL-1:0][MW:0]       off_b;
  logic [NL-1:0]             neg_b;
  logic [COORDS-1:0][CB-1:0] pa_b, pb_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_b <= acc_a;
      mva_b <= mva;
      mvb_b <= mvb;
      off_b <= off_c;
      neg_b <= neg_a;
      pa_b  <= pa_a;
      pb_b  <= pb_a;
    end
  end

  // stage c: move the outside endpoints, output register
  hlc_point_t ra_c, rb_c;

  always_comb begin
    logic signed [CB+1:0] sa, sb;
    logic signed [CB-1:0] fa, fb;
    for (int c = 0; c < COORDS; c++) begin
      sa = neg_b[c] ? ((CB+2)'(signed'(pa_b[c])) - signed'(off_b[c]))
                    : ((CB+2)'(signed'(pa_b[c])) + signed'(off_b[c]));
      sb = neg_b[c+COORDS]
             ? ((CB+2)'(signed'(pa_b[c])) - signed'(off_b[c+COORDS]))
             : ((CB+2)'(signed'(pa_b[c])) + signed'(off_b[c+COORDS]));
      fa = mva_b ? signed'(sa[CB-1:0]) : signed'(pa_b[c]);
      fb = mvb_b ? signed'(sb[CB-1:0]) : signed'(pb_b[c]);
      ra_c[c] = PORT_BITS'(fa);
      rb_c[c] = PORT_BITS'(fb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      accepted <= acc_b;
      ra       <= ra_c;
      rb       <= rb_c;
    end
  end

endmodule

[sv/homogeneous_line_clipper_core.sv]
// Homogeneous line clipper, top level.
// Channel seg (sink) takes one segment word: two clip-space points x, y, z, w,
// each signed Q16.16. Channel clip (source) returns one word per segment:
// accepted and both clipped endpoints, in the order the segments came in.
// The segment is clipped against -w <= x, y, z <= w. A rejected segment has
// accepted low and both points echoed; a segment wholly inside is echoed with
// accepted high.
// Throughput: one segment per cycle while clip is not stalled. The pipeline
// is one setup stage, then the divider, which resolves one quotient bit per
// stage for all six planes at once, then three stages of parameter
// selection, multiply and add.
// The whole pipeline advances together; when clip is stalled with a word
// waiting, seg.ready drops and every stage holds, so no word is lost or
// repeated. The last stage is the output register.
// Synchronous reset clears every stage valid; no word is held after reset.
// Depends on hlc_pkg, hlc_if, hlc_setup, hlc_div and hlc_lerp.
`timescale 1ns / 1ps

module homogeneous_line_clipper_core
  import hlc_pkg::*;
#(
  parameter int COORD_BITS      = 32,
  parameter int PARAM_FRAC_BITS = 24
) (
  input  logic      clk,
  input  logic      rst,
  hlc_seg_if.sink   seg,
  hlc_clip_if.source clip
);

  localparam int CB = COORD_BITS;
  localparam int PF = PARAM_FRAC_BITS;
  localparam int DW = CB + 3;
  localparam int SW = 2 * COORDS * CB + $bits(hlc_ctl_t);

  logic en;

  // whole pipeline moves unless a finished word is waiting
  assign en        = !clip.valid || clip.ready;
  assign seg.ready = en;

  hlc_point_t raw_a, raw_b;
  assign raw_a = {seg.first_w, seg.first_z, seg.first_y, seg.first_x};
  assign raw_b = {seg.second_w, seg.second_z, seg.second_y, seg.second_x};

  logic                      s_valid;
  logic [COORDS-1:0][CB-1:0] s_pa, s_pb;
  hlc_ctl_t                  s_ctl;
  logic [PLANES-1:0][CB:0]   s_num;
  logic [PLANES-1:0][DW-1:0] s_den;

  hlc_setup #(.CB(CB), .DW(DW)) u_setup (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (seg.valid),
    .raw_a     (raw_a),
    .raw_b     (raw_b),
    .out_valid (s_valid),
    .pa        (s_pa),
    .pb        (s_pb),
    .ctl       (s_ctl),
    .num       (s_num),
    .den       (s_den)
  );

  logic                      d_valid;
  logic [PLANES-1:0][PF-1:0] d_quo;
  logic [SW-1:0]             d_side;
  logic [COORDS-1:0][CB-1:0] d_pa, d_pb;
  hlc_ctl_t                  d_ctl;

  hlc_div #(.CB(CB), .PF(PF), .DW(DW), .SW(SW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .num       (s_num),
    .den       (s_den),
    .side_in   ({s_ctl, s_pb, s_pa}),
    .out_valid (d_valid),
    .quo       (d_quo),
    .side_out  (d_side)
  );

  // unpack the points and plane flags that ride along the divider
  assign {d_ctl, d_pb, d_pa} = d_side;

  hlc_point_t o_ra, o_rb;
  logic       o_valid, o_acc;

  hlc_lerp #(.CB(CB), .PF(PF)) u_lerp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .quo       (d_quo),
    .ctl       (d_ctl),
    .pa        (d_pa),
    .pb        (d_pb),
    .out_valid (o_valid),
    .accepted  (o_acc),
    .ra        (o_ra),
    .rb        (o_rb)
  );

  assign clip.valid            = o_valid;
  assign clip.accepted         = o_acc;
  assign clip.clipped_first_x  = o_ra[0];
  assign clip.clipped_first_y  = o_ra[1];
  assign clip.clipped_first_z  = o_ra[2];
  assign clip.clipped_first_w  = o_ra[3];
  assign clip.clipped_second_x = o_rb[0];
  assign clip.clipped_second_y = o_rb[1];
  assign clip.clipped_second_z = o_rb[2];
  assign clip.clipped_second_w = o_rb[3];

`ifndef ASSERT_OFF
  // reset empties the output stage
  a_rst_empty: assert property (@(posedge clk) rst |=> !clip.valid)
    else $error("output valid after reset");

  // a waiting output word must hold back the input side
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    (clip.valid && !clip.ready) |-> !seg.ready)
    else $error("input taken while output stalled");

  // a stalled word keeps its decision until taken
  a_hold_acc: assert property (@(posedge clk) disable iff (rst)
    (clip.valid && !clip.ready) |=> $stable(clip.accepted))
    else $error("accepted changed under stall");
`endif

endmodule
